// ===== rtl/gregorian_date_add_days_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the calendar date block
// Concurrent checks that compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset
`define GDA_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Same-cycle implication
`define GDA_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
`else
`define GDA_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define GDA_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/gda_pkg.sv =====
// ---------------------------------------------------------------------------
// gda_pkg
// Shared types, field layout and calendar helpers for the date block.
// ---------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  // Field widths
  localparam int YEAR_IN_W  = 16;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int DAYS_IN_W  = 16;
  localparam int STATUS_W   = 2;

  // Input tdata layout: new_year, new_month, new_day, days_to_add
  localparam int IN_YEAR_LSB  = 0;
  localparam int IN_MONTH_LSB = IN_YEAR_LSB + YEAR_IN_W;
  localparam int IN_DAY_LSB   = IN_MONTH_LSB + MONTH_W;
  localparam int IN_DAYS_LSB  = IN_DAY_LSB + DAY_W;
  localparam int IN_DATA_W    = 48;

  // Output tdata layout: cur_year, cur_month, cur_day, status
  localparam int OUT_FIELDS_W = YEAR_IN_W + MONTH_W + DAY_W + STATUS_W;
  localparam int OUT_DATA_W   = 32;

  // Calendar constants
  localparam int LEAP_CYCLE      = 400;
  localparam int CENTURY         = 100;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int MONTH_JAN       = 1;
  localparam int DAYS_LONG       = 31;
  localparam int DAYS_SHORT      = 30;
  localparam int DAYS_FEB        = 28;
  localparam int DAYS_FEB_LEAP   = 29;

  // Year mod 400 tracking; 400 = 16 * 25, quotient by 25 through a reciprocal
  localparam int REM_W     = 9;
  localparam int REM_LO_W  = 4;
  localparam int REM_ODD   = 25;
  localparam int REM_ODD_W = 5;
  localparam int QUOT_W    = 8;
  localparam int RECIP_SH  = 16;
  // ceil(2^16 / 25); exact for every 12-bit dividend
  localparam int RECIP_ODD = 2622;

  // Reset date: 1970-01-01
  localparam int RESET_YEAR = 1970;
  localparam int RESET_M400 = RESET_YEAR % LEAP_CYCLE;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_BAD_LOAD = 2'd1,
    STS_WRAP     = 2'd2
  } status_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_ADD  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_CHECK,
    S_ADD,
    S_DONE
  } state_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

  // Month step unit status
  typedef struct packed {
    logic last;
    logic wrap;
  } step_sts_t;

  // Leap year from year mod 4 (low bits) and year mod 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [REM_W-1:0] m400);
    logic century;
    century = (m400 == REM_W'(CENTURY)) || (m400 == REM_W'(2 * CENTURY)) ||
              (m400 == REM_W'(3 * CENTURY));
    return (y_lo == 2'b00) && !century;
  endfunction

  // Month length; zero for a month outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] dim;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = DAY_W'(DAYS_LONG);
      4'd4, 4'd6, 4'd9, 4'd11:                   dim = DAY_W'(DAYS_SHORT);
      4'd2:    dim = leap ? DAY_W'(DAYS_FEB_LEAP) : DAY_W'(DAYS_FEB);
      default: dim = '0;
    endcase
    return dim;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gda_rem400.sv =====
// ---------------------------------------------------------------------------
// gda_rem400
// Year mod 400 in two steps: reciprocal multiply for the quotient by 25,
// then a multiply-subtract for the remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module gda_rem400 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [gda_pkg::YEAR_IN_W-1:0] value,
  output gda_pkg::rem_sts_t                  sts,
  output logic      [gda_pkg::REM_W-1:0]     rem
);

  // year = 16 * hi + lo, so year mod 400 = 16 * (hi mod 25) + lo
  localparam int HI_W   = gda_pkg::YEAR_IN_W - gda_pkg::REM_LO_W;
  localparam int PROD_W = gda_pkg::RECIP_SH + gda_pkg::QUOT_W;

  logic                           quot_busy_r, quot_busy_nxt;
  logic                           sub_busy_r, sub_busy_nxt;
  logic                           done_r, done_nxt;
  logic [gda_pkg::YEAR_IN_W-1:0]  val_r, val_nxt;
  logic [gda_pkg::QUOT_W-1:0]     quot_r, quot_nxt;
  logic [gda_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [HI_W-1:0]                hi;
  logic [PROD_W-1:0]              prod;
  logic [HI_W-1:0]                hi_mod;

  // Quotient step, then remainder step
  always_comb begin
    hi            = val_r[gda_pkg::YEAR_IN_W-1 -: HI_W];
    prod          = PROD_W'(hi) * PROD_W'(gda_pkg::RECIP_ODD);
    hi_mod        = hi - HI_W'(quot_r) * HI_W'(gda_pkg::REM_ODD);
    quot_busy_nxt = 1'b0;
    sub_busy_nxt  = 1'b0;
    done_nxt      = 1'b0;
    val_nxt       = val_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    if (start) begin
      val_nxt       = value;
      quot_busy_nxt = 1'b1;
    end
    if (quot_busy_r) begin
      quot_nxt     = prod[PROD_W-1 -: gda_pkg::QUOT_W];
      sub_busy_nxt = 1'b1;
    end
    if (sub_busy_r) begin
      rem_nxt  = {hi_mod[gda_pkg::REM_ODD_W-1:0], val_r[gda_pkg::REM_LO_W-1:0]};
      done_nxt = 1'b1;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_busy_r <= 1'b0;
      sub_busy_r  <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      quot_busy_r <= quot_busy_nxt;
      sub_busy_r  <= sub_busy_nxt;
      done_r      <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.busy = quot_busy_r || sub_busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

endmodule

`default_nettype wire

// ===== rtl/gda_step.sv =====
// ---------------------------------------------------------------------------
// gda_step
// One month step of the add: finish inside the month or roll to the next.
// ---------------------------------------------------------------------------
`default_nettype none

module gda_step #(
  parameter int YEAR_BITS = 16,
  parameter int ADD_BITS  = 16
) (
  input  wire logic [YEAR_BITS-1:0]          year,
  input  wire logic [gda_pkg::REM_W-1:0]     m400,
  input  wire logic [gda_pkg::MONTH_W-1:0]   month,
  input  wire logic [gda_pkg::DAY_W-1:0]     day,
  input  wire logic [ADD_BITS-1:0]           left,
  output logic      [YEAR_BITS-1:0]          year_out,
  output logic      [gda_pkg::REM_W-1:0]     m400_out,
  output logic      [gda_pkg::MONTH_W-1:0]   month_out,
  output logic      [gda_pkg::DAY_W-1:0]     day_out,
  output logic      [ADD_BITS-1:0]           left_out,
  output gda_pkg::step_sts_t                 sts
);

  localparam int SUM_W = ((ADD_BITS > gda_pkg::DAY_W) ? ADD_BITS : gda_pkg::DAY_W) + 1;

  logic                        leap;
  logic [gda_pkg::DAY_W-1:0]   dim;
  logic [SUM_W-1:0]            sum;
  logic [gda_pkg::DAY_W:0]     gap;
  logic [SUM_W-1:0]            diff;

  always_comb begin
    leap = gda_pkg::is_leap(year[1:0], m400);
    dim  = gda_pkg::month_days(month, leap);
    sum  = SUM_W'(left) + SUM_W'(day);
    // days to reach the first of next month
    gap  = {1'b0, dim} - {1'b0, day} + (gda_pkg::DAY_W + 1)'(1);
    diff = SUM_W'(left) - SUM_W'(gap);

    year_out  = year;
    m400_out  = m400;
    month_out = month;
    day_out   = day;
    left_out  = left;
    sts       = '0;

    if (sum <= SUM_W'(dim)) begin
      // lands inside this month
      day_out  = sum[gda_pkg::DAY_W-1:0];
      left_out = '0;
      sts.last = 1'b1;
    end else begin
      left_out = diff[ADD_BITS-1:0];
      day_out  = gda_pkg::DAY_W'(1);
      if (month == gda_pkg::MONTH_W'(gda_pkg::MONTHS_PER_YEAR)) begin
        month_out = gda_pkg::MONTH_W'(gda_pkg::MONTH_JAN);
        if (year == '1) begin
          // year wraps to 0, which is a leap year
          year_out = '0;
          m400_out = '0;
          sts.wrap = 1'b1;
        end else begin
          year_out = year + YEAR_BITS'(1);
          if (m400 == gda_pkg::REM_W'(gda_pkg::LEAP_CYCLE - 1)) begin
            m400_out = '0;
          end else begin
            m400_out = m400 + gda_pkg::REM_W'(1);
          end
        end
      end else begin
        month_out = month + gda_pkg::MONTH_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// ---------------------------------------------------------------------------
// gregorian_date_add_days
// Calendar date register with validated load and add-days by month steps.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+-------------
//  in_     | in  | new_year, new_month, new_day, days_to_add| mode
//  out_    | out | cur_year, cur_month, cur_day, status     | -
//
//  Add: S_IDLE accepts the item, S_ADD takes one month step per crossed month
//    in the month step unit up to the landing step, then S_DONE sends the result.
//  Load: S_REM waits on the two-step mod-400 unit for the leap check.
//  Reset: date 1970-01-01, no transaction pending.
//  The result waits in an output register; the next item is accepted while
//    it waits, and that item's result holds in S_DONE until the register frees.
//
`default_nettype none

module gregorian_date_add_days #(
  parameter int YEAR_BITS = 16,
  parameter int ADD_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // new_year[15:0], new_month[19:16], new_day[24:20], days_to_add[40:25], zero pad
  input  wire logic [gda_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode[0]
  input  wire logic [0:0]                      in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // cur_year[15:0], cur_month[19:16], cur_day[24:20], status[26:25], zero pad
  output logic      [gda_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready
);

`include "gregorian_date_add_days_assert.svh"

  gda_pkg::state_t                   state_r, state_nxt;
  gda_pkg::status_t                  status_r, status_nxt;
  logic [YEAR_BITS-1:0]              year_r, year_nxt;
  logic [gda_pkg::REM_W-1:0]         m400_r, m400_nxt;
  logic [gda_pkg::MONTH_W-1:0]       month_r, month_nxt;
  logic [gda_pkg::DAY_W-1:0]         day_r, day_nxt;
  logic [ADD_BITS-1:0]               left_r, left_nxt;
  logic [gda_pkg::YEAR_IN_W-1:0]     ld_year_r, ld_year_nxt;
  logic [gda_pkg::MONTH_W-1:0]       ld_month_r, ld_month_nxt;
  logic [gda_pkg::DAY_W-1:0]         ld_day_r, ld_day_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [gda_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                              in_xfer;
  gda_pkg::mode_t                    in_mode;
  logic [gda_pkg::YEAR_IN_W-1:0]     in_year;
  logic [gda_pkg::DAYS_IN_W-1:0]     in_days;
  logic                              rem_start;
  gda_pkg::rem_sts_t                 rem_sts;
  logic [gda_pkg::REM_W-1:0]         rem;

  logic [YEAR_BITS-1:0]              st_year;
  logic [gda_pkg::REM_W-1:0]         st_m400;
  logic [gda_pkg::MONTH_W-1:0]       st_month;
  logic [gda_pkg::DAY_W-1:0]         st_day;
  logic [ADD_BITS-1:0]               st_left;
  gda_pkg::step_sts_t                st_sts;

  logic [31:0]                       ld_year_ext;
  logic                              ld_fits;
  logic [gda_pkg::DAY_W-1:0]         ld_dim;
  logic                              ld_ok;
  logic [47:0]                       year_ext;
  logic [gda_pkg::DAY_W-1:0]         cur_dim;

  // Input field unpacking
  assign in_tready = (state_r == gda_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_mode   = gda_pkg::mode_t'(in_tuser[0]);
  assign in_year   = in_tdata[gda_pkg::IN_YEAR_LSB +: gda_pkg::YEAR_IN_W];
  assign in_days   = in_tdata[gda_pkg::IN_DAYS_LSB +: gda_pkg::DAYS_IN_W];
  assign rem_start = in_xfer && (in_mode == gda_pkg::MODE_LOAD);

  // Year mod 400 for load validation
  gda_rem400 u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .value (in_year),
    .sts   (rem_sts),
    .rem   (rem)
  );

  // Month step unit for the add
  gda_step #(
    .YEAR_BITS (YEAR_BITS),
    .ADD_BITS  (ADD_BITS)
  ) u_step (
    .year      (year_r),
    .m400      (m400_r),
    .month     (month_r),
    .day       (day_r),
    .left      (left_r),
    .year_out  (st_year),
    .m400_out  (st_m400),
    .month_out (st_month),
    .day_out   (st_day),
    .left_out  (st_left),
    .sts       (st_sts)
  );

  // Load check and output formatting
  always_comb begin
    ld_year_ext = 32'(ld_year_r);
    ld_fits     = (ld_year_ext >> YEAR_BITS) == 32'd0;
    ld_dim      = gda_pkg::month_days(ld_month_r, gda_pkg::is_leap(ld_year_r[1:0], rem));
    ld_ok       = ld_fits && (ld_dim != '0) && (ld_day_r != '0) && (ld_day_r <= ld_dim);
    year_ext    = 48'(year_r);
    cur_dim     = gda_pkg::month_days(month_r, gda_pkg::is_leap(year_r[1:0], m400_r));
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    year_nxt      = year_r;
    m400_nxt      = m400_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    left_nxt      = left_r;
    ld_year_nxt   = ld_year_r;
    ld_month_nxt  = ld_month_r;
    ld_day_nxt    = ld_day_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      gda_pkg::S_IDLE: begin
        if (in_xfer) begin
          status_nxt   = gda_pkg::STS_OK;
          ld_year_nxt  = in_year;
          ld_month_nxt = in_tdata[gda_pkg::IN_MONTH_LSB +: gda_pkg::MONTH_W];
          ld_day_nxt   = in_tdata[gda_pkg::IN_DAY_LSB +: gda_pkg::DAY_W];
          left_nxt     = ADD_BITS'(in_days);
          state_nxt    = (in_mode == gda_pkg::MODE_ADD) ? gda_pkg::S_ADD : gda_pkg::S_REM;
        end
      end
      gda_pkg::S_REM: begin
        if (rem_sts.done) begin
          state_nxt = gda_pkg::S_CHECK;
        end
      end
      gda_pkg::S_CHECK: begin
        if (ld_ok) begin
          year_nxt  = YEAR_BITS'(ld_year_ext);
          m400_nxt  = rem;
          month_nxt = ld_month_r;
          day_nxt   = ld_day_r;
        end else begin
          status_nxt = gda_pkg::STS_BAD_LOAD;
        end
        state_nxt = gda_pkg::S_DONE;
      end
      gda_pkg::S_ADD: begin
        year_nxt  = st_year;
        m400_nxt  = st_m400;
        month_nxt = st_month;
        day_nxt   = st_day;
        left_nxt  = st_left;
        if (st_sts.wrap) begin
          status_nxt = gda_pkg::STS_WRAP;
        end
        if (st_sts.last) begin
          state_nxt = gda_pkg::S_DONE;
        end
      end
      gda_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = gda_pkg::OUT_DATA_W'({status_r, day_r, month_r, year_ext[15:0]});
          state_nxt     = gda_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gda_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Date and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= YEAR_BITS'(gda_pkg::RESET_YEAR);
      m400_r      <= gda_pkg::REM_W'(gda_pkg::RESET_M400);
      month_r     <= gda_pkg::MONTH_W'(gda_pkg::MONTH_JAN);
      day_r       <= gda_pkg::DAY_W'(1);
      status_r    <= gda_pkg::STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      year_r      <= year_nxt;
      m400_r      <= m400_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    ld_year_r  <= ld_year_nxt;
    ld_month_r <= ld_month_nxt;
    ld_day_r   <= ld_day_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `GDA_ASSERT_ALWAYS(a_month_range, clk, rst_n, (month_r >= 4'd1) && (month_r <= 4'd12), "stored month out of range")
  `GDA_ASSERT_ALWAYS(a_day_range, clk, rst_n, (day_r != '0) && (day_r <= cur_dim), "stored day outside month")
  `GDA_ASSERT_ALWAYS(a_m400_sync, clk, rst_n, m400_r[1:0] == year_r[1:0], "year mod 400 tracking lost")
  `GDA_ASSERT_IMPLIES(a_rem_done_state, clk, rst_n, rem_sts.done, state_r == gda_pkg::S_REM, "remainder done outside load")
  `GDA_ASSERT_IMPLIES(a_idle_rem_quiet, clk, rst_n, state_r == gda_pkg::S_IDLE, !rem_sts.busy, "remainder unit busy while idle")

endmodule

`default_nettype wire

// ===== sim/tb_gregorian_date_add_days.sv =====
// ---------------------------------------------------------------------------
// tb_gregorian_date_add_days
// Stream testbench for the calendar date block. A queue of load and add
// transactions is played in random bursts. A calendar predictor updated on
// each accepted input builds the expected date and status, and the monitor
// checks every accepted result against the oldest one. The receiver stalls
// on its own pattern and sometimes holds off long enough to back up the input.
// ---------------------------------------------------------------------------

module tb_gregorian_date_add_days;

  localparam int RANDOM_ITEMS   = 248;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_EVERY  = 140;
  localparam int YEAR_TOP       = 65535;

  // One input transaction
  typedef struct {
    gda_pkg::mode_t mode;
    logic [15:0]    year;
    logic [3:0]     month;
    logic [4:0]     day;
    logic [15:0]    days;
  } date_cmd_t;

  // One result transaction
  typedef struct {
    logic [15:0]      year;
    logic [3:0]       month;
    logic [4:0]       day;
    gda_pkg::status_t status;
  } date_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  // new_year[15:0], new_month[19:16], new_day[24:20], days_to_add[40:25], zero pad
  logic [gda_pkg::IN_DATA_W-1:0] in_tdata   = '0;
  // mode[0]
  logic [0:0]                    in_tuser   = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  // cur_year[15:0], cur_month[19:16], cur_day[24:20], status[26:25], zero pad
  logic [gda_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;

  date_cmd_t pending_cmds[$];
  date_t     expected_dates[$];
  date_cmd_t on_bus;

  // Predicted calendar state, starts at the reset date
  int unsigned cal_year  = 1970;
  int unsigned cal_month = 1;
  int unsigned cal_day   = 1;

  int   burst_left      = 1;
  int   gap_left        = 0;
  int   results_seen    = 0;
  int   mismatches      = 0;
  int   idle_cycles     = 0;
  int   holdoff_left    = 0;
  int   next_holdoff_at = 40;
  logic [15:0] stall_cycle = '0;
  logic ready_bit;

  gregorian_date_add_days u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gregorian leap rule: every 400th year, else every 4th but not every 100th
  function automatic bit leap_year(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Append to the tail of the pending and expected queues
  function automatic void queue_cmd(date_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void queue_expected(date_t r);
    expected_dates.insert(expected_dates.size(), r);
  endfunction

  // Update the predicted date for one accepted transaction, queue the result
  function automatic void apply_to_calendar(date_cmd_t c);
    date_t       res;
    int unsigned n;
    int unsigned dim;
    int unsigned ld_year;
    int unsigned ld_month;
    int unsigned ld_day;
    res.status = gda_pkg::STS_OK;
    ld_year    = 32'(c.year);
    ld_month   = 32'(c.month);
    ld_day     = 32'(c.day);
    if (c.mode == gda_pkg::MODE_LOAD) begin
      dim = month_length(ld_year, ld_month);
      if (dim == 0 || ld_day == 0 || ld_day > dim) begin
        res.status = gda_pkg::STS_BAD_LOAD;
      end else begin
        cal_year  = ld_year;
        cal_month = ld_month;
        cal_day   = ld_day;
      end
    end else begin
      n = 32'(c.days);
      // step one month at a time until the remaining count fits
      while (n != 0) begin
        dim = month_length(cal_year, cal_month);
        if (n + cal_day <= dim) begin
          cal_day += n;
          n = 0;
        end else begin
          n -= dim - cal_day + 1;
          cal_day = 1;
          cal_month++;
          if (cal_month > 12) begin
            cal_month = 1;
            if (cal_year >= YEAR_TOP) begin
              cal_year   = 0;
              res.status = gda_pkg::STS_WRAP;
            end else begin
              cal_year++;
            end
          end
        end
      end
    end
    res.year  = cal_year[15:0];
    res.month = cal_month[3:0];
    res.day   = cal_day[4:0];
    queue_expected(res);
  endfunction

  // Load with random filler in the unused day count
  function automatic date_cmd_t load_cmd(int unsigned y, int unsigned m, int unsigned d);
    date_cmd_t c;
    c.mode  = gda_pkg::MODE_LOAD;
    c.year  = y[15:0];
    c.month = m[3:0];
    c.day   = d[4:0];
    c.days  = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // Add with random filler in the unused date fields
  function automatic date_cmd_t add_cmd(int unsigned n);
    date_cmd_t c;
    c.mode  = gda_pkg::MODE_ADD;
    c.year  = 16'($urandom_range(0, 65535));
    c.month = 4'($urandom_range(0, 15));
    c.day   = 5'($urandom_range(0, 31));
    c.days  = n[15:0];
    return c;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch on result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned pick, y, m, d, n, sz;

    // directed: zero add, leap rules, bad fields, year wrap, largest counts
    queue_cmd(add_cmd(0));
    queue_cmd(add_cmd(1));
    queue_cmd(load_cmd(2000, 2, 29));
    queue_cmd(load_cmd(1900, 2, 29));
    queue_cmd(load_cmd(2004, 2, 29));
    queue_cmd(load_cmd(2001, 2, 29));
    queue_cmd(load_cmd(2020, 0, 1));
    queue_cmd(load_cmd(2020, 13, 1));
    queue_cmd(load_cmd(YEAR_TOP, 15, 31));
    queue_cmd(load_cmd(2020, 5, 0));
    queue_cmd(load_cmd(2021, 4, 31));
    queue_cmd(load_cmd(0, 2, 29));
    queue_cmd(load_cmd(2023, 12, 31));
    queue_cmd(add_cmd(1));
    queue_cmd(load_cmd(2024, 2, 28));
    queue_cmd(add_cmd(1));
    queue_cmd(add_cmd(1));
    queue_cmd(load_cmd(YEAR_TOP, 12, 31));
    queue_cmd(add_cmd(1));
    queue_cmd(add_cmd(65535));
    queue_cmd(load_cmd(YEAR_TOP, 1, 1));
    queue_cmd(add_cmd(65535));
    queue_cmd(add_cmd(0));

    // random: mostly valid loads and short adds, a few long adds
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(65300, YEAR_TOP)
                                        : $urandom_range(0, YEAR_TOP);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(y, m));
        queue_cmd(load_cmd(y, m, d));
      end else if (pick < 40) begin
        queue_cmd(load_cmd($urandom_range(0, YEAR_TOP), $urandom_range(0, 15),
                           $urandom_range(0, 31)));
      end else begin
        sz = $urandom_range(0, 9);
        if (sz < 7)      n = $urandom_range(0, 60);
        else if (sz < 9) n = $urandom_range(61, 3000);
        else             n = $urandom_range(3001, 65535);
        queue_cmd(add_cmd(n));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid || expected_dates.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_to_calendar(on_bus);
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          on_bus = pending_cmds.pop_front();
          in_tuser  <= on_bus.mode;
          in_tdata  <= gda_pkg::IN_DATA_W'({on_bus.days, on_bus.day, on_bus.month,
                                            on_bus.year});
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1, 2:    gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 25);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (results_seen >= next_holdoff_at) begin
      holdoff_left    <= HOLDOFF_CYCLES;
      next_holdoff_at <= next_holdoff_at + HOLDOFF_EVERY;
    end
  end

  // Receiver stall pattern: steady, coin flip, sparse, alternating
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[7:6])
        2'd0:    ready_bit = 1'b1;
        2'd1:    ready_bit = $urandom_range(0, 1);
        2'd2:    ready_bit = ($urandom_range(0, 3) == 0);
        default: ready_bit = stall_cycle[1];
      endcase
      out_tready <= ready_bit && (holdoff_left == 0);
    end
  end

  // Monitor: compare each result transaction with the oldest predicted date
  always @(posedge clk) begin
    date_t got;
    date_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.year   = out_tdata[15:0];
      got.month  = out_tdata[19:16];
      got.day    = out_tdata[24:20];
      got.status = gda_pkg::status_t'(out_tdata[26:25]);
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("unexpected %0d-%0d-%0d status %0d",
                                  got.year, got.month, got.day, got.status));
      end else begin
        want = expected_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || got.status !== want.status)
          report_mismatch($sformatf("got %0d-%0d-%0d status %0d, want %0d-%0d-%0d status %0d",
                                    got.year, got.month, got.day, got.status,
                                    want.year, want.month, want.day, want.status));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
